// ===== rtl/core/apnm_pkg.sv =====
package apnm_pkg;

  localparam int unsigned MaxElevations = 32;
  localparam int unsigned MaxAzimuths   = 1024;
  localparam int unsigned MaxPairs      = 4096;
  localparam int unsigned MaxDuplicates = 256;

  localparam int unsigned AzW  = 16;
  localparam int unsigned ElW  = 15;
  localparam int unsigned KeyW = AzW + ElW;

  localparam int unsigned ElIdxW  = $clog2(MaxElevations);
  localparam int unsigned AzIdxW  = $clog2(MaxAzimuths);
  localparam int unsigned PrIdxW  = $clog2(MaxPairs);
  localparam int unsigned DupIdxW = $clog2(MaxDuplicates);
  localparam int unsigned ElCntW  = $clog2(MaxElevations + 1);
  localparam int unsigned AzCntW  = $clog2(MaxAzimuths + 1);
  localparam int unsigned PrCntW  = $clog2(MaxPairs + 1);
  localparam int unsigned DupCntW = $clog2(MaxDuplicates + 1);

  // Input tdata: operation, entry_index, azimuth, elevation (40 bits with pad)
  localparam int unsigned InW  = 40;
  // Output tdata: status, matched_azimuth, matched_elevation, is_duplicate
  localparam int unsigned OutW = 40;

  localparam logic [1:0] OpLoad  = 2'd0;
  localparam logic [1:0] OpAdd   = 2'd1;
  localparam logic [1:0] OpQuery = 2'd2;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StNoMatch = 2'd1;
  localparam logic [1:0] StDup     = 2'd2;
  localparam logic [1:0] StFull    = 2'd3;

  localparam logic CfgAzTol = 1'b0;
  localparam logic CfgElTol = 1'b1;

  // One step request to the shared nearest-distance unit
  typedef struct packed {
    logic              first;
    logic signed [AzW:0] probe;
    logic signed [AzW:0] entry;
  } near_req_t;

  function automatic logic [KeyW-1:0] pack_key(logic [AzW-1:0] az, logic [ElW-1:0] el);
    return {az, el};
  endfunction

endpackage

// ===== rtl/core/angle_pair_nearest_match_table.sv =====
// Angle pair nearest-match table.
// Input items arrive on s_axis (tdata: operation, entry_index, azimuth,
// elevation). Each item yields one result on m_axis (status,
// matched_azimuth, matched_elevation, is_duplicate). Tolerances are written
// through cfg_we_i/cfg_idx_i/cfg_data_i; the user must write them only
// while the block is idle, which the block itself does not enforce.
// One item at a time: s_axis_tready is high only when no item is in work.
// A load writes one elevation entry. An add scans the azimuth table (one
// entry a cycle), then the elevation table, then the pair table, then
// writes. A query scans azimuth, elevation and duplicate tables. Items
// that end at the elevation step (no match, full azimuth table) skip the
// last scan.
// The rate is set by the single read port of each table and the one shared
// distance unit, which sees one entry per cycle.
// Reset clears all counts and tolerances; table contents stay undefined and
// only entries below the counts are ever read, so no clearing pass is needed.
// A finished result is held in the output register until m_axis_tready is
// high; the block takes no new item until then.
module angle_pair_nearest_match_table (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // [1:0] operation, [6:2] entry_index, [22:7] azimuth, [37:23] elevation
  input  logic [apnm_pkg::InW-1:0]     s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [1:0] status, [17:2] matched_azimuth, [32:18] matched_elevation, [33] is_duplicate
  output logic [apnm_pkg::OutW-1:0]    m_axis_tdata,
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [apnm_pkg::AzW-1:0]     cfg_data_i
);

  localparam int unsigned AzW  = apnm_pkg::AzW;
  localparam int unsigned ElW  = apnm_pkg::ElW;
  localparam int unsigned KeyW = apnm_pkg::KeyW;

  localparam logic [3:0] SIdle  = 4'd0;
  localparam logic [3:0] SAzScan = 4'd1;
  localparam logic [3:0] SAzFin  = 4'd2;
  localparam logic [3:0] SElScan = 4'd3;
  localparam logic [3:0] SElFin  = 4'd4;
  localparam logic [3:0] SKeyScan = 4'd5;
  localparam logic [3:0] SKeyFin  = 4'd6;
  localparam logic [3:0] SOut    = 4'd7;
  localparam logic [3:0] SQAzFin = 4'd8;

  logic [3:0] state_q, state_d;

  logic [AzW-1:0] az_tol_q;
  logic [ElW-1:0] el_tol_q;

  logic [1:0]             op_q;
  logic [AzW-1:0]         az_q;
  logic signed [ElW-1:0]  el_q;

  logic [apnm_pkg::ElCntW-1:0]  el_cnt_q;
  logic [apnm_pkg::AzCntW-1:0]  az_cnt_q;
  logic [apnm_pkg::PrCntW-1:0]  pr_cnt_q;
  logic [apnm_pkg::DupCntW-1:0] dup_cnt_q;

  // Scan counter wide enough for the largest table
  logic [apnm_pkg::PrCntW-1:0] scan_q;
  logic [apnm_pkg::PrCntW-1:0] rd_addr;
  logic                        rd_vld_q;
  logic                        rd_first_q;
  logic                        found_q;
  logic                        az_ok_q;
  logic [AzW-1:0]              hit_az_q;
  logic signed [ElW-1:0]       hit_el_q;

  logic [1:0]           res_status_q;
  logic [AzW-1:0]       res_az_q;
  logic [ElW-1:0]       res_el_q;
  logic                 res_dup_q;
  logic                 out_vld_q;

  // Memories
  logic [ElW-1:0]  el_mem [apnm_pkg::MaxElevations];
  logic [AzW-1:0]  az_mem [apnm_pkg::MaxAzimuths];
  logic [KeyW-1:0] pr_mem [apnm_pkg::MaxPairs];
  logic [KeyW-1:0] dup_mem [apnm_pkg::MaxDuplicates];
  logic [ElW-1:0]  el_rd_q;
  logic [AzW-1:0]  az_rd_q;
  logic [KeyW-1:0] pr_rd_q;
  logic [KeyW-1:0] dup_rd_q;

  logic                 in_acc;
  logic [1:0]           in_op;
  logic [4:0]           in_idx;
  logic [AzW:0]         best_dist;
  logic signed [AzW:0]  best_val;
  apnm_pkg::near_req_t  nreq;
  logic                 nstep;
  logic [KeyW-1:0]      key;

  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign in_op  = s_axis_tdata[1:0];
  assign in_idx = s_axis_tdata[6:2];
  assign s_axis_tready = (state_q == SIdle) && !out_vld_q;
  assign key = apnm_pkg::pack_key(op_q == apnm_pkg::OpAdd ? az_q : hit_az_q, hit_el_q);

  // Feed the shared distance unit from whichever table is read
  always_comb begin
    nreq.first = rd_first_q;
    nstep      = rd_vld_q && (state_q == SAzScan || state_q == SAzFin ||
                              state_q == SElScan || state_q == SElFin);
    if (state_q == SElScan || state_q == SElFin) begin
      nreq.probe = (AzW+1)'(el_q);
      nreq.entry = (AzW+1)'($signed(el_rd_q));
    end else begin
      nreq.probe = $signed({1'b0, az_q});
      nreq.entry = $signed({1'b0, az_rd_q});
    end
    if (op_q == apnm_pkg::OpAdd) nstep = nstep && (state_q == SElScan || state_q == SElFin);
  end

  apnm_near u_near (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (nstep),
    .req_i       (nreq),
    .best_dist_o (best_dist),
    .best_val_o  (best_val)
  );

  // Fetch entry 0 on the edge that starts a scan, then follow the scan counter
  assign rd_addr = (state_q inside {SIdle, SAzFin, SQAzFin, SElFin}) ? '0 : scan_q;

  // Registered table reads
  always_ff @(posedge clk_i) begin
    el_rd_q  <= el_mem[rd_addr[apnm_pkg::ElIdxW-1:0]];
    az_rd_q  <= az_mem[rd_addr[apnm_pkg::AzIdxW-1:0]];
    pr_rd_q  <= pr_mem[rd_addr[apnm_pkg::PrIdxW-1:0]];
    dup_rd_q <= dup_mem[rd_addr[apnm_pkg::DupIdxW-1:0]];
  end

  // Table writes
  always_ff @(posedge clk_i) begin
    if (in_acc && in_op == apnm_pkg::OpLoad) begin
      el_mem[in_idx[apnm_pkg::ElIdxW-1:0]] <= s_axis_tdata[37:23];
    end
    if (state_q == SElFin && op_q == apnm_pkg::OpAdd && !az_ok_q &&
        az_cnt_q < apnm_pkg::AzCntW'(apnm_pkg::MaxAzimuths))
      az_mem[az_cnt_q[apnm_pkg::AzIdxW-1:0]] <= az_q;
    if (state_q == SOut && op_q == apnm_pkg::OpAdd && res_status_q == apnm_pkg::StOk &&
        res_az_q == az_q && !rd_first_q)
      pr_mem[pr_cnt_q[apnm_pkg::PrIdxW-1:0]] <= {res_az_q, res_el_q};
    if (state_q == SOut && op_q == apnm_pkg::OpAdd && res_status_q == apnm_pkg::StDup &&
        !rd_first_q)
      dup_mem[dup_cnt_q[apnm_pkg::DupIdxW-1:0]] <= {res_az_q, res_el_q};
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; az_tol_q <= '0; el_tol_q <= '0;
      el_cnt_q <= '0; az_cnt_q <= '0; pr_cnt_q <= '0; dup_cnt_q <= '0;
      out_vld_q <= 1'b0; rd_vld_q <= 1'b0; rd_first_q <= 1'b0;
      scan_q <= '0; found_q <= 1'b0; az_ok_q <= 1'b0; op_q <= '0;
      res_status_q <= '0; res_az_q <= '0; res_el_q <= '0; res_dup_q <= 1'b0;
      az_q <= '0; el_q <= '0; hit_az_q <= '0; hit_el_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == apnm_pkg::CfgAzTol) az_tol_q <= cfg_data_i;
        else el_tol_q <= cfg_data_i[ElW-1:0];
      end
      if (out_vld_q && m_axis_tready) out_vld_q <= 1'b0;
      rd_first_q <= 1'b0;
      case (state_q)
        SIdle: begin
          rd_vld_q <= 1'b0;
          if (in_acc) begin
            op_q <= in_op; az_q <= s_axis_tdata[22:7]; el_q <= s_axis_tdata[37:23];
            res_status_q <= apnm_pkg::StOk; res_az_q <= '0; res_el_q <= '0;
            res_dup_q <= 1'b0; found_q <= 1'b0; az_ok_q <= 1'b0; scan_q <= '0;
            if (in_op == apnm_pkg::OpLoad) begin
              if ({1'b0, in_idx} + 6'd1 > 6'(el_cnt_q))
                el_cnt_q <= apnm_pkg::ElCntW'({1'b0, in_idx} + 6'd1);
              out_vld_q <= 1'b1;
            end else if (in_op == apnm_pkg::OpAdd || in_op == apnm_pkg::OpQuery) begin
              rd_vld_q <= az_cnt_q != '0; rd_first_q <= 1'b1;
              scan_q <= apnm_pkg::PrCntW'(1);
            end else begin
              out_vld_q <= 1'b1;
            end
          end
        end
        SAzScan: begin
          // One azimuth entry per cycle: exact compare for add, nearest for query
          if (rd_vld_q && az_rd_q == az_q) found_q <= 1'b1;
          rd_vld_q <= scan_q < apnm_pkg::PrCntW'(az_cnt_q);
          scan_q <= scan_q + 1'b1;
        end
        SAzFin: begin
          az_ok_q <= found_q;
          if (op_q == apnm_pkg::OpQuery) begin
            found_q <= (az_cnt_q != '0) && best_dist < (AzW+1)'(az_tol_q);
            hit_az_q <= best_val[AzW-1:0];
          end
          scan_q <= apnm_pkg::PrCntW'(1); rd_vld_q <= el_cnt_q != '0; rd_first_q <= 1'b1;
        end
        SQAzFin: begin
          scan_q <= apnm_pkg::PrCntW'(1); rd_vld_q <= el_cnt_q != '0; rd_first_q <= 1'b1;
        end
        SElScan: begin
          rd_vld_q <= scan_q < apnm_pkg::PrCntW'(el_cnt_q);
          scan_q <= scan_q + 1'b1;
        end
        SElFin: begin
          hit_el_q <= best_val[ElW-1:0];
          if (op_q == apnm_pkg::OpQuery) begin
            if (!(found_q && el_cnt_q != '0 && best_dist < (AzW+1)'(el_tol_q))) begin
              res_status_q <= apnm_pkg::StNoMatch;
              out_vld_q <= 1'b1;
            end else begin
              res_az_q <= hit_az_q; res_el_q <= best_val[ElW-1:0];
            end
          end else begin
            if (!az_ok_q && az_cnt_q >= apnm_pkg::AzCntW'(apnm_pkg::MaxAzimuths)) begin
              res_status_q <= apnm_pkg::StFull; out_vld_q <= 1'b1;
            end else begin
              if (!az_ok_q) begin
                az_cnt_q <= az_cnt_q + 1'b1;
              end
              if (!(el_cnt_q != '0 && best_dist < (AzW+1)'(el_tol_q))) begin
                res_status_q <= apnm_pkg::StNoMatch; out_vld_q <= 1'b1;
              end else begin
                res_az_q <= az_q; res_el_q <= best_val[ElW-1:0];
              end
            end
          end
          found_q <= 1'b0;
          scan_q <= apnm_pkg::PrCntW'(1);
          rd_vld_q <= (op_q == apnm_pkg::OpAdd) ? pr_cnt_q != '0 : dup_cnt_q != '0;
        end
        SKeyScan: begin
          if (rd_vld_q && ((op_q == apnm_pkg::OpAdd) ? pr_rd_q == key : dup_rd_q == key))
            found_q <= 1'b1;
          rd_vld_q <= (op_q == apnm_pkg::OpAdd) ? scan_q < pr_cnt_q
                                                : scan_q < apnm_pkg::PrCntW'(dup_cnt_q);
          scan_q <= scan_q + 1'b1;
        end
        SKeyFin: begin
          if (op_q == apnm_pkg::OpQuery) begin
            res_dup_q <= found_q;
          end else if (found_q) begin
            res_status_q <= (dup_cnt_q < apnm_pkg::DupCntW'(apnm_pkg::MaxDuplicates)) ?
                            apnm_pkg::StDup : apnm_pkg::StFull;
          end else if (pr_cnt_q >= apnm_pkg::PrCntW'(apnm_pkg::MaxPairs)) begin
            res_status_q <= apnm_pkg::StFull;
          end
        end
        SOut: begin
          // Commit the pair or duplicate log, then present the result
          if (op_q == apnm_pkg::OpAdd && res_status_q == apnm_pkg::StOk)
            pr_cnt_q <= pr_cnt_q + 1'b1;
          if (op_q == apnm_pkg::OpAdd && res_status_q == apnm_pkg::StDup)
            dup_cnt_q <= dup_cnt_q + 1'b1;
          out_vld_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      SIdle:
        if (in_acc && (in_op == apnm_pkg::OpAdd || in_op == apnm_pkg::OpQuery))
          state_d = SAzScan;
      SAzScan:  if (!rd_vld_q || scan_q > apnm_pkg::PrCntW'(az_cnt_q)) state_d = SAzFin;
      SAzFin:   state_d = SElScan;
      SQAzFin:  state_d = SElScan;
      SElScan:  if (!rd_vld_q || scan_q > apnm_pkg::PrCntW'(el_cnt_q)) state_d = SElFin;
      SElFin: begin
        if (op_q == apnm_pkg::OpQuery) begin
          state_d = (found_q && el_cnt_q != '0 && best_dist < (AzW+1)'(el_tol_q)) ?
                    SKeyScan : SIdle;
        end else if ((!az_ok_q && az_cnt_q >= apnm_pkg::AzCntW'(apnm_pkg::MaxAzimuths)) ||
                     !(el_cnt_q != '0 && best_dist < (AzW+1)'(el_tol_q))) begin
          state_d = SIdle;
        end else begin
          state_d = SKeyScan;
        end
      end
      SKeyScan: begin
        if (!rd_vld_q ||
            scan_q > ((op_q == apnm_pkg::OpAdd) ? pr_cnt_q : apnm_pkg::PrCntW'(dup_cnt_q)))
          state_d = SKeyFin;
      end
      SKeyFin:  state_d = SOut;
      SOut:     state_d = SIdle;
      default:  state_d = SIdle;
    endcase
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {6'd0, res_dup_q, res_el_q, res_az_q, res_status_q};

  // Pair and duplicate counts never exceed capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pr_cnt_q <= apnm_pkg::PrCntW'(apnm_pkg::MaxPairs))
    else $error("pair count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dup_cnt_q <= apnm_pkg::DupCntW'(apnm_pkg::MaxDuplicates))
    else $error("duplicate count overflow");
  // No new item while a result waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input taken while result pending");

endmodule

// ===== rtl/core/apnm_near.sv =====
// Shared nearest-entry tracker: one absolute difference and compare per cycle.
module apnm_near (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           step_i,
  input  apnm_pkg::near_req_t            req_i,
  output logic [apnm_pkg::AzW:0]         best_dist_o,
  output logic signed [apnm_pkg::AzW:0]  best_val_o
);

  logic signed [apnm_pkg::AzW+1:0] diff;
  logic        [apnm_pkg::AzW:0]   adist;
  logic        [apnm_pkg::AzW:0]   best_dist_q;
  logic signed [apnm_pkg::AzW:0]   best_val_q;

  // Form the absolute distance of one entry
  always_comb begin
    diff  = {req_i.entry[apnm_pkg::AzW], req_i.entry} - {req_i.probe[apnm_pkg::AzW], req_i.probe};
    adist = diff[apnm_pkg::AzW+1] ? (apnm_pkg::AzW+1)'(-diff)
                                  : diff[apnm_pkg::AzW:0];
  end

  // Keep the strictly closer entry; the earliest wins a tie
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_dist_q <= '0;
      best_val_q  <= '0;
    end else if (step_i && (req_i.first || adist < best_dist_q)) begin
      best_dist_q <= adist;
      best_val_q  <= req_i.entry;
    end
  end

  assign best_dist_o = best_dist_q;
  assign best_val_o  = best_val_q;

endmodule
